/* rtl/assert_macros.svh */
// Assertion macros used by the RTL of the takeover angle blend block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/stab_pkg.sv */
// Types, constants and the microprogram of the takeover angle blend block.
`default_nettype none

package stab_pkg;

    // Micro-operations issued to the datapath, one per step.
    typedef enum logic [3:0] {
        UOP_LOAD,   // take the input transfer, apply restart, remove offset
        UOP_PREP,   // wrapped difference, saturation test, counter advance
        UOP_DIV,    // two quotient bits of alpha
        UOP_SQR,    // alpha squared, shaping weight 3 - 2*alpha
        UOP_CUBE,   // alpha^2 times weight
        UOP_SRND,   // round shaped alpha
        UOP_STEP,   // shaped alpha times difference
        UOP_BLEND,  // round step and add to open-loop angle
        UOP_MAG,    // magnitude and sign for radians, error against reference
        UOP_RADM,   // magnitude times two pi
        UOP_RRND,   // round radians
        UOP_OUT,    // load the output register
        UOP_NOP
    } t_uop;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_IF_SAT,
        JMP_LOOP,
        JMP_WAIT_IN,
        JMP_WAIT_OUT
    } t_jump;

    typedef logic [3:0] t_pc;
    typedef logic [2:0] t_iter;

    typedef struct packed {
        t_uop  uop;
        t_jump jump;
        t_pc   target;
    } t_uword;

    // Sequencer to datapath.
    typedef struct packed {
        t_uop uop;
    } t_ctrl;

    // Datapath to sequencer.
    typedef struct packed {
        logic in_valid;
        logic sat;
        logic out_busy;
    } t_cond;

    typedef enum logic [0:0] {
        REG_TAKEOVER_TICKS,
        REG_ANGLE_OFFSET
    } t_reg_idx;

    localparam t_pc   PC_START  = 4'd0;
    localparam t_pc   PC_DIV    = 4'd2;
    localparam t_pc   PC_SQR    = 4'd3;
    localparam int    DIV_ITERS = 8;
    localparam t_iter ITER_LAST = 3'(DIV_ITERS - 1);

    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [17:0] THREE_Q16  = 18'd196608;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

    function automatic t_uword stab_program(input t_pc pc);
        t_uword w;
        case (pc)
            4'd0:    w = '{UOP_LOAD,  JMP_WAIT_IN,  PC_START};
            4'd1:    w = '{UOP_PREP,  JMP_IF_SAT,   PC_SQR};
            4'd2:    w = '{UOP_DIV,   JMP_LOOP,     PC_DIV};
            4'd3:    w = '{UOP_SQR,   JMP_NEXT,     PC_START};
            4'd4:    w = '{UOP_CUBE,  JMP_NEXT,     PC_START};
            4'd5:    w = '{UOP_SRND,  JMP_NEXT,     PC_START};
            4'd6:    w = '{UOP_STEP,  JMP_NEXT,     PC_START};
            4'd7:    w = '{UOP_BLEND, JMP_NEXT,     PC_START};
            4'd8:    w = '{UOP_MAG,   JMP_NEXT,     PC_START};
            4'd9:    w = '{UOP_RADM,  JMP_NEXT,     PC_START};
            4'd10:   w = '{UOP_RRND,  JMP_NEXT,     PC_START};
            4'd11:   w = '{UOP_OUT,   JMP_WAIT_OUT, PC_START};
            default: w = '{UOP_NOP,   JMP_GOTO,     PC_START};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/stab_seq.sv */
// Microprogram sequencer: step counter, loop counter and control word fetch.
`default_nettype none

module stab_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stab_pkg::t_cond i_cond,
    output stab_pkg::t_ctrl o_ctrl
);
    import stab_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_iter  r_iter;
    t_iter  n_iter;
    t_uword w_word;

    assign w_word     = stab_program(r_pc);
    assign o_ctrl.uop = w_word.uop;

    always_comb begin
        case (w_word.jump)
            JMP_NEXT:     n_pc = 4'(r_pc + 4'd1);
            JMP_GOTO:     n_pc = w_word.target;
            JMP_IF_SAT:   n_pc = i_cond.sat ? w_word.target : 4'(r_pc + 4'd1);
            JMP_LOOP:     n_pc = (r_iter != '0) ? w_word.target : 4'(r_pc + 4'd1);
            JMP_WAIT_IN:  n_pc = i_cond.in_valid ? 4'(r_pc + 4'd1) : r_pc;
            JMP_WAIT_OUT: n_pc = i_cond.out_busy ? r_pc : w_word.target;
            default:      n_pc = PC_START;
        endcase

        case (w_word.uop)
            UOP_PREP: n_iter = ITER_LAST;
            UOP_DIV:  n_iter = 3'(r_iter - 3'd1);
            default:  n_iter = r_iter;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= PC_START;
            r_iter <= '0;
        end else begin
            r_pc   <= n_pc;
            r_iter <= n_iter;
        end
    end

endmodule

`default_nettype wire

/* rtl/sensorless_takeover_angle_blend_core.sv */
// A new input is taken only after the previous result has loaded the output register;
//   alpha is formed by an eight-step radix-4 division, skipped once the blend has
//   saturated, and a waiting result holds the output step.
// The next input transfer can be taken in the cycle after the result loads the output register.
// Reset (synchronous, active low) clears both registers, the progress counter,
//   the sequencer and the output valid.
`default_nettype none
`include "assert_macros.svh"

module sensorless_takeover_angle_blend_core #(
    parameter int ANGLE_BITS = 16,
    parameter int COUNT_BITS = 16,
    localparam int CFG_W = (ANGLE_BITS > 16) ? ANGLE_BITS : 16,
    localparam int IN_W  = ((3 * ANGLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * ANGLE_BITS + 16 + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  stab_pkg::t_reg_idx   i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // open_loop_angle, raw_estimator_angle, reference_angle (lowest bits first)
    input  logic [IN_W-1:0]      s_axis_tdata,
    // restart
    input  logic                 s_axis_tuser,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // blended_angle, blended_angle_rad, angle_error (lowest bits first)
    output logic [OUT_W-1:0]     m_axis_tdata,
    // blend_done
    output logic                 m_axis_tuser
);
    import stab_pkg::*;

    localparam int AB    = ANGLE_BITS;
    localparam int CW    = COUNT_BITS;
    localparam int CMP_W = (CW > 16) ? CW : 16;
    localparam int MA_W  = 34;
    localparam int MB_W  = 33;
    localparam int PW    = MA_W + MB_W;
    localparam logic [AB-1:0] HALF = {1'b1, {(AB-1){1'b0}}};

    // ---------------------------------------------------------------
    // Sequencer: the control program walks LOAD, PREP, the division loop
    // (skipped once alpha has saturated), then a fixed chain of multiply and
    // rounding steps, and parks on OUT while the output register is still occupied.
    // ---------------------------------------------------------------
    t_ctrl w_ctrl;
    t_cond w_cond;
    logic  w_in_accept;
    logic  w_sat;

    // control state
    logic [15:0]   r_ticks;
    logic [AB-1:0] r_offset;
    logic [CW-1:0] r_cnt;
    logic          r_mvalid;

    // datapath
    logic [AB-1:0]          r_ol;
    logic [AB-1:0]          r_est;
    logic [AB-1:0]          r_ref;
    logic signed [AB-1:0]   r_d;
    logic                   r_done;
    logic [15:0]            r_rem;
    logic [16:0]            r_quo;
    logic [17:0]            r_w;
    logic [16:0]            r_s;
    logic signed [PW-1:0]   r_prod;
    logic [AB-1:0]          r_blend;
    logic [AB-1:0]          r_mag;
    logic                   r_neg;
    logic [AB-1:0]          r_err;
    logic [15:0]            r_rad;

    // output register
    logic [AB-1:0] r_o_blend;
    logic [15:0]   r_o_rad;
    logic [AB-1:0] r_o_err;
    logic          r_o_done;

    logic [CMP_W-1:0] w_cnt_ext;
    logic [CMP_W-1:0] w_ticks_ext;
    logic             w_out_busy;

    // hold tready low while reset is held so no transfer is taken then
    assign s_axis_tready = i_rst_n && (w_ctrl.uop == UOP_LOAD);
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_busy    = r_mvalid && !m_axis_tready;

    // Alpha saturates at one when the counter has reached the blend length;
    // a zero blend length falls out of the same compare.
    assign w_cnt_ext   = CMP_W'(r_cnt);
    assign w_ticks_ext = CMP_W'(r_ticks);
    assign w_sat       = (w_cnt_ext >= w_ticks_ext);

    assign w_cond.in_valid = s_axis_tvalid;
    assign w_cond.sat      = w_sat;
    assign w_cond.out_busy = w_out_busy;

    stab_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (w_cond),
        .o_ctrl  (w_ctrl)
    );

    // ---------------------------------------------------------------
    // Radix-4 restoring division: two quotient bits of
    // (count << 16) / ticks per step. Remainder stays below ticks.
    // ---------------------------------------------------------------
    logic [16:0] w_r2;
    logic [16:0] w_r2s;
    logic [16:0] w_r3;
    logic [16:0] w_r3s;
    logic        w_q1;
    logic        w_q0;
    logic [15:0] n_rem;
    logic [16:0] n_quo;

    always_comb begin
        w_r2  = {r_rem, 1'b0};
        w_q1  = (w_r2 >= {1'b0, r_ticks});
        w_r2s = w_q1 ? 17'(w_r2 - {1'b0, r_ticks}) : w_r2;
        w_r3  = {w_r2s[15:0], 1'b0};
        w_q0  = (w_r3 >= {1'b0, r_ticks});
        w_r3s = w_q0 ? 17'(w_r3 - {1'b0, r_ticks}) : w_r3;
        n_rem = w_r3s[15:0];
        n_quo = {r_quo[14:0], w_q1, w_q0};
    end

    // ---------------------------------------------------------------
    // Shared signed multiplier, operands picked by the micro-op.
    // ---------------------------------------------------------------
    logic signed [MA_W-1:0] w_mul_a;
    logic signed [MB_W-1:0] w_mul_b;
    logic                   w_mul_en;

    always_comb begin
        w_mul_en = 1'b1;
        case (w_ctrl.uop)
            UOP_SQR: begin
                w_mul_a = MA_W'(r_quo);
                w_mul_b = MB_W'(r_quo);
            end
            UOP_CUBE: begin
                w_mul_a = MA_W'(r_prod[32:0]);
                w_mul_b = MB_W'(r_w);
            end
            UOP_STEP: begin
                w_mul_a = MA_W'(r_d);
                w_mul_b = MB_W'(r_s);
            end
            UOP_RADM: begin
                w_mul_a = MA_W'(r_mag);
                w_mul_b = MB_W'(TWO_PI_Q29);
            end
            default: begin
                w_mul_a  = '0;
                w_mul_b  = '0;
                w_mul_en = 1'b0;
            end
        endcase
    end

    // rounding adders
    logic [49:0]    w_s_rnd;
    logic [AB+15:0] w_blend_sum;
    logic [AB+31:0] w_rad_rnd;

    assign w_s_rnd     = r_prod[49:0] + 50'h80000000;
    assign w_blend_sum = r_prod[AB+15:0] + {r_ol, 16'h8000};
    assign w_rad_rnd   = r_prod[AB+31:0] + ((AB+32)'(1) << (AB + 15));

    // ---------------------------------------------------------------
    // Control state: registers, progress counter, output valid.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks  <= '0;
            r_offset <= '0;
            r_cnt    <= '0;
            r_mvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TAKEOVER_TICKS: r_ticks  <= i_cfg_data[15:0];
                    REG_ANGLE_OFFSET:   r_offset <= i_cfg_data[AB-1:0];
                    default: ;
                endcase
            end

            // restart clears the counter before this tick's blend
            if (w_in_accept && s_axis_tuser) begin
                r_cnt <= '0;
            end else if (w_ctrl.uop == UOP_PREP && !w_sat && r_cnt != '1) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end

            if (w_ctrl.uop == UOP_OUT && !w_out_busy) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath payload.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end

        case (w_ctrl.uop)
            UOP_LOAD: begin
                if (w_in_accept) begin
                    r_ol  <= s_axis_tdata[AB-1:0];
                    r_est <= AB'(s_axis_tdata[2*AB-1:AB] - r_offset);
                    r_ref <= s_axis_tdata[3*AB-1:2*AB];
                end
            end
            UOP_PREP: begin
                // wraps to the half turn as two's complement
                r_d    <= AB'(r_est - r_ol);
                r_done <= w_sat;
                r_rem  <= w_cnt_ext[15:0];
                r_quo  <= w_sat ? ONE_Q16 : 17'd0;
            end
            UOP_DIV: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
            end
            UOP_SQR: begin
                r_w <= 18'(THREE_Q16 - {r_quo, 1'b0});
            end
            UOP_SRND: begin
                r_s <= w_s_rnd[48:32];
            end
            UOP_BLEND: begin
                r_blend <= w_blend_sum[AB+15:16];
            end
            UOP_MAG: begin
                // above half a turn counts as negative
                r_neg <= (r_blend > HALF);
                r_mag <= (r_blend > HALF) ? AB'(0 - r_blend) : r_blend;
                r_err <= AB'(r_blend - r_ref);
            end
            UOP_RRND: begin
                r_rad <= w_rad_rnd[AB+31:AB+16];
            end
            UOP_OUT: begin
                if (!w_out_busy) begin
                    r_o_blend <= r_blend;
                    r_o_rad   <= r_neg ? 16'(16'd0 - r_rad) : r_rad;
                    r_o_err   <= r_err;
                    r_o_done  <= r_done;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = OUT_W'({r_o_err, r_o_rad, r_o_blend});
    assign m_axis_tuser  = r_o_done;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_NEXT(a_accept_starts_prep, i_clk, i_rst_n,
        w_in_accept, w_ctrl.uop == UOP_PREP,
        "accepted item did not start preparation")
    `ASSERT_IMPLIES(a_valid_from_out, i_clk, i_rst_n,
        $rose(m_axis_tvalid), $past(w_ctrl.uop == UOP_OUT),
        "result valid rose outside the output step")
    `ASSERT_IMPLIES(a_cnt_changes_in_place, i_clk, i_rst_n,
        r_cnt != $past(r_cnt),
        $past(w_ctrl.uop == UOP_LOAD) || $past(w_ctrl.uop == UOP_PREP),
        "progress counter moved outside load or prep")
    `ASSERT_IMPLIES(a_cnt_steps_by_one, i_clk, i_rst_n,
        $past(w_ctrl.uop == UOP_PREP) && r_cnt != $past(r_cnt),
        r_cnt == CW'($past(r_cnt) + 1'b1),
        "progress counter jumped by more than one")

endmodule

`default_nettype wire

/* tb/blend_angle_checker.sv */
// Checker for the takeover angle blend: predicts each result and compares it.
`timescale 1ns / 100ps

module blend_angle_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  stab_pkg::t_reg_idx   i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [47:0]          i_in_data,
    input  logic                 i_in_user,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [47:0]          i_out_data,
    input  logic                 i_out_user,
    output int                   o_pending,
    output int                   o_fail_count
);
    import stab_pkg::*;

    localparam longint unsigned RAD_PER_TURN_Q29 = 64'd3373259426;
    localparam int              MAX_PRINTED      = 40;

    typedef struct packed {
        logic [15:0] angle;
        logic [15:0] rad;
        logic [15:0] err;
        logic        done;
    } blend_out_t;

    logic [15:0] ticks_reg;
    logic [15:0] offset_reg;
    logic [15:0] progress;
    blend_out_t  pending_blends[$];
    blend_out_t  want;
    blend_out_t  got;
    int          fail_total = 0;

    function automatic blend_out_t predict_blend(input logic [15:0] ol, input logic [15:0] raw,
                                                 input logic [15:0] enc, input logic [15:0] cnt);
        logic [15:0]     est;
        logic [15:0]     diff;
        logic [15:0]     blended;
        logic [15:0]     mag;
        logic            neg;
        longint          alpha;
        longint          shaped;
        longint          prod;
        longint          step;
        longint unsigned rad_u;
        blend_out_t      r;
        est  = raw - offset_reg;
        diff = est - ol;
        // alpha in Q1.16, one when the blend length is zero
        if (ticks_reg == 16'd0) begin
            alpha = 65536;
        end else begin
            alpha = (longint'(cnt) * 65536) / longint'(ticks_reg);
            if (alpha > 65536) begin
                alpha = 65536;
            end
        end
        shaped = (alpha * alpha * (longint'(196608) - 2 * alpha) + (longint'(1) << 31)) >>> 32;
        prod   = shaped * longint'($signed(diff)) + 32768;
        step   = prod >>> 16;
        blended = ol + step[15:0];
        // radians: angles past half a turn are taken as negative
        neg   = blended > 16'h8000;
        mag   = neg ? (16'h0000 - blended) : blended;
        rad_u = (64'(mag) * RAD_PER_TURN_Q29 + 64'h8000_0000) >> 32;
        r.angle = blended;
        r.rad   = neg ? 16'(64'd0 - rad_u) : rad_u[15:0];
        r.err   = blended - enc;
        r.done  = cnt >= ticks_reg;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] seen,
                                   input logic [15:0] exp_val);
        if (fail_total < MAX_PRINTED) begin
            $display("%0t: %s mismatch, got %h want %h", $realtime, what, seen, exp_val);
        end
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ticks_reg  = '0;
            offset_reg = '0;
            progress   = '0;
            pending_blends.delete();
            o_pending    <= 0;
            o_fail_count <= fail_total;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TAKEOVER_TICKS: ticks_reg  = i_cfg_data;
                    REG_ANGLE_OFFSET:   offset_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_user) begin
                    progress = '0;
                end
                pending_blends.push_back(predict_blend(i_in_data[15:0], i_in_data[31:16],
                                                       i_in_data[47:32], progress));
                // advance toward the blend length, never past all ones
                if (progress < ticks_reg && progress != 16'hFFFF) begin
                    progress = progress + 16'd1;
                end
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_out_data[15:0], i_out_data[31:16], i_out_data[47:32], i_out_user};
                if (pending_blends.size() == 0) begin
                    report_mismatch("unexpected result", got.angle, 16'h0000);
                end else begin
                    want = pending_blends.pop_front();
                    if (got.angle !== want.angle)
                        report_mismatch("blended_angle", got.angle, want.angle);
                    if (got.rad !== want.rad)
                        report_mismatch("blended_angle_rad", got.rad, want.rad);
                    if (got.err !== want.err)
                        report_mismatch("angle_error", got.err, want.err);
                    if (got.done !== want.done)
                        report_mismatch("blend_done", 16'(got.done), 16'(want.done));
                end
            end
            o_pending    <= pending_blends.size();
            o_fail_count <= fail_total;
        end
    end

endmodule

/* tb/sensorless_takeover_angle_blend_core_tb.sv */
// Testbench top for the takeover angle blend core: stimulus, handshake idling and verdict.
`timescale 1ns / 100ps

module sensorless_takeover_angle_blend_core_tb;
    import stab_pkg::*;

    localparam int ITEMS_PER_PHASE = 50;
    localparam int RANDOM_PHASES   = 9;
    localparam int MAX_GAP         = 6;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_reg_idx    i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;

    int          pending;
    int          fail_count;
    logic        quiet;        // no idling on either side while set
    logic [15:0] cur_offset;   // offset last written, to build half-turn differences
    int          sink_gap;
    int          sink_stall;

    always #5 i_clk = ~i_clk;

    sensorless_takeover_angle_blend_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    blend_angle_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_in_user    (s_tuser),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_out_user   (m_tuser),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Result side: after each transfer draw a stall, hold tready low for it,
    // then raise tready and keep it up until the next transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            sink_stall <= 0;
        end else if (m_tvalid && m_tready) begin
            sink_gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
            m_tready   <= (sink_gap == 0);
            sink_stall <= sink_gap;
        end else if (sink_stall > 0) begin
            m_tready   <= (sink_stall == 1);
            sink_stall <= sink_stall - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Send one tick. Drop tvalid only when a gap is drawn, so a back-to-back
    // transfer keeps tvalid high without a low/high pair in one time step.
    task automatic send_tick(input logic [15:0] ol, input logic [15:0] raw,
                             input logic [15:0] enc, input logic restart);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {enc, raw, ol};
        s_tuser  <= restart;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Hold off the sender until every expected result has been taken.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers while the block is idle.
    task automatic set_regs(input logic [15:0] ticks, input logic [15:0] offset);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_TAKEOVER_TICKS;
        i_cfg_data <= ticks;
        @(posedge i_clk);
        i_cfg_idx  <= REG_ANGLE_OFFSET;
        i_cfg_data <= offset;
        cur_offset = offset;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly uniform angles, with the turn boundaries thrown in now and then.
    function automatic logic [15:0] pick_angle();
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0:       return 16'h0000;
                1:       return 16'hFFFF;
                2:       return 16'h7FFF;
                default: return 16'h8000;
            endcase
        end
        return 16'($urandom);
    endfunction

    initial begin
        logic [15:0] ol;
        logic [15:0] raw;
        logic [15:0] ticks;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_TAKEOVER_TICKS;
        i_cfg_data <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= 1'b0;
        quiet      <= 1'b0;
        cur_offset = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: zero blend length, so the output is the estimator angle.
        send_tick(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_tick(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        send_tick(16'h0000, 16'h8000, 16'h0000, 1'b0);   // exact half-turn difference
        send_tick(16'h1234, 16'hFFFF, 16'h0000, 1'b1);
        send_tick(16'h8001, 16'h7FFF, 16'h8000, 1'b0);

        // Short blend with a half-turn offset: walk the counter to saturation.
        set_regs(16'd4, 16'h8000);
        send_tick(16'h0000, 16'h0000, 16'h8000, 1'b1);
        send_tick(16'h4000, 16'h4000, 16'h0000, 1'b0);   // half-turn difference
        send_tick(16'hFFFF, 16'h0001, 16'h0001, 1'b0);
        send_tick(16'h2000, 16'hE000, 16'hFFFF, 1'b0);
        send_tick(16'hC000, 16'h3000, 16'h7FFF, 1'b0);
        send_tick(16'h7FFF, 16'h8000, 16'h8000, 1'b0);
        send_tick(16'h0001, 16'hFFFE, 16'h0000, 1'b0);

        // Lower the blend length under the counter: alpha saturates, counter holds.
        set_regs(16'd1, 16'h8000);
        send_tick(16'h1111, 16'h5555, 16'hAAAA, 1'b0);
        send_tick(16'hF000, 16'h0F00, 16'h0000, 1'b0);
        send_tick(16'h8000, 16'h0000, 16'hFFFF, 1'b0);

        // Longest blend and largest offset.
        set_regs(16'hFFFF, 16'hFFFF);
        send_tick(16'h0000, 16'hFFFF, 16'h0000, 1'b1);
        send_tick(16'hFFFF, 16'h0000, 16'h8000, 1'b0);
        send_tick(16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
        send_tick(16'h5A5A, 16'hA5A5, 16'hFFFF, 1'b0);

        // Random phases, each with its own register setting; the counter carries
        // over between phases, so lowered blend lengths show up too.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: set_regs(16'd0, 16'd0);
                1: set_regs(16'hFFFF, 16'hFFFF);
                2: set_regs(16'd1, 16'($urandom));
                default: begin
                    case ($urandom_range(0, 7))
                        5:       ticks = 16'd0;
                        6:       ticks = 16'($urandom_range(25, 200));
                        7:       ticks = 16'($urandom);
                        default: ticks = 16'($urandom_range(1, 24));
                    endcase
                    set_regs(ticks, 16'($urandom));
                end
            endcase
            quiet <= (ph % 3 == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                ol  = pick_angle();
                raw = pick_angle();
                if ($urandom_range(0, 15) == 0) begin
                    raw = ol + 16'h8000 + cur_offset;   // exact half-turn difference
                end
                send_tick(ol, raw, pick_angle(), ($urandom_range(0, 31) == 0));
                // Pause the sender now and then until all results are back.
                if ((ph == 4 && n == ITEMS_PER_PHASE / 2) || $urandom_range(0, 63) == 0) begin
                    drain();
                end
            end
        end

        drain();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
